/* src/cec_rx_pkg.sv */
`timescale 1ns / 1ps
// Package for the CEC bit receiver: phase encoding, timing windows and
// field widths. No dependencies.
package cec_rx_pkg;

  localparam int FRAME_BYTES_DEF = 16;

  localparam logic [3:0] BROADCAST_ADDR = 4'hf;
  localparam logic [3:0] OWN_ADDR_RST   = 4'hf;

  localparam logic [31:0] START_LOW_MIN  = 32'd3500;
  localparam logic [31:0] START_LOW_MAX  = 32'd3900;
  localparam logic [31:0] START_PER_MIN  = 32'd4300;
  localparam logic [31:0] START_PER_MAX  = 32'd4700;
  localparam logic [31:0] BIT_PER_MIN    = 32'd2050;
  localparam logic [31:0] BIT_PER_MAX    = 32'd2750;
  localparam logic [31:0] ONE_LOW_MIN    = 32'd400;
  localparam logic [31:0] ONE_LOW_MAX    = 32'd800;
  localparam logic [31:0] ZERO_LOW_MIN   = 32'd1300;
  localparam logic [31:0] ZERO_LOW_MAX   = 32'd1700;

  localparam logic ACT_EDGE  = 1'b0;
  localparam logic ACT_REARM = 1'b1;

  typedef enum logic [9:0] {
    PH_START_LOW  = 10'b00_0000_0001,
    PH_START_HIGH = 10'b00_0000_0010,
    PH_DATA_LOW   = 10'b00_0000_0100,
    PH_DATA_HIGH  = 10'b00_0000_1000,
    PH_EOM_LOW    = 10'b00_0001_0000,
    PH_EOM_HIGH   = 10'b00_0010_0000,
    PH_ACK_LOW    = 10'b00_0100_0000,
    PH_ACK_HIGH   = 10'b00_1000_0000,
    PH_DONE       = 10'b01_0000_0000,
    PH_ABORT      = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic ok;
    logic value;
  } bit_dec_t;

  function automatic logic in_window(input logic [31:0] v, input logic [31:0] lo,
                                     input logic [31:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic bit_dec_t low_to_bit(input logic [31:0] low);
    bit_dec_t d;
    d.ok    = 1'b0;
    d.value = 1'b0;
    if (in_window(low, ONE_LOW_MIN, ONE_LOW_MAX)) begin
      d.ok    = 1'b1;
      d.value = 1'b1;
    end else if (in_window(low, ZERO_LOW_MIN, ZERO_LOW_MAX)) begin
      d.ok    = 1'b1;
      d.value = 1'b0;
    end
    return d;
  endfunction

endpackage

/* src/cec_bit_receiver_top.sv */
`timescale 1ns / 1ps
// CEC bit receiver: decodes timestamped line edges into bytes and frame status.
// Depends on cec_rx_pkg.
//
// channel   direction  tdata / data                         tuser
// s_*       in         [0] edge_rising, [32:1] edge_time_us  [0] action
// m_*       out        see port comment                      -
// cfg_*     in         [3:0] own_address                    -
//
// One transaction per cycle while m_tready is high; input register, then decode
// into the result register. A stall on m_tready holds the result
// and lets one more transaction wait in the input register before s_tready
// drops. rst clears the frame state, empties both registers and sets
// own_address to 15. cfg_ready is always high.
module cec_bit_receiver_top
  import cec_rx_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] edge_rising, [32:1] edge_time_us, [39:33] zero
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] ack_pull, [1] byte_valid, [9:2] byte_value,
                                 // [13:10] byte_index, [14] frame_done,
                                 // [19:15] frame_length, [20] acked_frame,
                                 // [21] aborted, [23:22] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  // input register
  logic        in_valid;
  logic        in_action;
  logic        in_rising;
  logic [31:0] in_time;

  // frame state
  phase_t      phase, phase_next;
  logic [31:0] last_mark_time, last_mark_time_next;
  logic        first_bit_pending, first_bit_pending_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  dest_nibble, dest_nibble_next;
  logic        eom_seen, eom_seen_next;
  logic        acked_flag, acked_flag_next;
  logic        abort_flag, abort_flag_next;
  logic        ready_flag, ready_flag_next;
  logic [3:0]  own_address;

  // step results
  logic        ack_pull_c;
  logic        byte_valid_c;
  logic [7:0]  byte_value_c;
  logic [3:0]  byte_index_c;

  logic        advance;
  logic        step;
  logic [31:0] delta;
  bit_dec_t    dec;
  logic [7:0]  shifted;
  logic [5:0]  count_ext;
  logic [5:0]  count_next_ext;

  assign advance   = !m_tvalid || m_tready;
  assign step      = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  assign delta     = in_time - last_mark_time;
  assign dec       = low_to_bit(delta);
  assign shifted   = {shift_byte[6:0], dec.value};
  assign count_ext = 6'(byte_count);
  assign count_next_ext = 6'(byte_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser[0];
      in_rising <= s_tdata[0];
      in_time   <= s_tdata[32:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      own_address <= cfg_data;
    end
  end

  always_comb begin
    phase_next             = phase;
    last_mark_time_next    = last_mark_time;
    first_bit_pending_next = first_bit_pending;
    byte_count_next        = byte_count;
    bit_count_next         = bit_count;
    shift_byte_next        = shift_byte;
    dest_nibble_next       = dest_nibble;
    eom_seen_next          = eom_seen;
    acked_flag_next        = acked_flag;
    abort_flag_next        = abort_flag;
    ready_flag_next        = ready_flag;
    ack_pull_c             = 1'b0;
    byte_valid_c           = 1'b0;
    byte_value_c           = 8'd0;
    byte_index_c           = 4'd0;

    if (in_action == ACT_REARM) begin
      phase_next             = PH_START_LOW;
      last_mark_time_next    = 32'd0;
      first_bit_pending_next = 1'b0;
      byte_count_next        = '0;
      bit_count_next         = 4'd0;
      shift_byte_next        = 8'd0;
      dest_nibble_next       = 4'd0;
      eom_seen_next          = 1'b0;
      acked_flag_next        = 1'b0;
      abort_flag_next        = 1'b0;
      ready_flag_next        = 1'b0;
    end else begin
      case (phase)
        PH_START_LOW: begin
          if (!in_rising) begin
            last_mark_time_next = in_time;
            phase_next          = PH_START_HIGH;
          end
        end
        PH_START_HIGH: begin
          if (in_rising) begin
            if (in_window(delta, START_LOW_MIN, START_LOW_MAX)) begin
              first_bit_pending_next = 1'b1;
              byte_count_next        = '0;
              bit_count_next         = 4'd0;
              shift_byte_next        = 8'd0;
              phase_next             = PH_DATA_LOW;
            end else begin
              phase_next      = PH_ABORT;
              abort_flag_next = 1'b1;
            end
          end
        end
        PH_DATA_LOW, PH_EOM_LOW: begin
          if (!in_rising) begin
            if (phase == PH_DATA_LOW && bit_count == 4'd0 &&
                byte_count >= CW'(MAX_FRAME_BYTES)) begin
              phase_next      = PH_ABORT;
              abort_flag_next = 1'b1;
            end else if (first_bit_pending ?
                         in_window(delta, START_PER_MIN, START_PER_MAX) :
                         in_window(delta, BIT_PER_MIN, BIT_PER_MAX)) begin
              last_mark_time_next    = in_time;
              first_bit_pending_next = 1'b0;
              phase_next = (phase == PH_EOM_LOW) ? PH_EOM_HIGH : PH_DATA_HIGH;
            end else begin
              phase_next      = PH_ABORT;
              abort_flag_next = 1'b1;
            end
          end
        end
        PH_DATA_HIGH, PH_EOM_HIGH: begin
          if (in_rising) begin
            if (!dec.ok) begin
              phase_next      = PH_ABORT;
              abort_flag_next = 1'b1;
            end else if (phase == PH_EOM_HIGH) begin
              eom_seen_next = dec.value;
              phase_next    = PH_ACK_LOW;
            end else if (bit_count == 4'd7) begin
              byte_valid_c    = 1'b1;
              byte_value_c    = shifted;
              byte_index_c    = count_ext[3:0];
              if (byte_count == '0) begin
                dest_nibble_next = shifted[3:0];
              end
              byte_count_next = byte_count + CW'(1);
              bit_count_next  = 4'd0;
              shift_byte_next = 8'd0;
              phase_next      = PH_EOM_LOW;
            end else begin
              shift_byte_next = shifted;
              bit_count_next  = bit_count + 4'd1;
              phase_next      = PH_DATA_LOW;
            end
          end
        end
        PH_ACK_LOW: begin
          if (!in_rising) begin
            last_mark_time_next = in_time;
            if (dest_nibble != BROADCAST_ADDR && dest_nibble == own_address) begin
              ack_pull_c      = 1'b1;
              acked_flag_next = 1'b1;
            end
            phase_next = PH_ACK_HIGH;
          end
        end
        PH_ACK_HIGH: begin
          if (in_rising) begin
            if (!dec.ok) begin
              phase_next      = PH_ABORT;
              abort_flag_next = 1'b1;
            end else if (eom_seen) begin
              phase_next      = PH_DONE;
              ready_flag_next = 1'b1;
            end else begin
              phase_next = PH_DATA_LOW;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_START_LOW;
      last_mark_time    <= 32'd0;
      first_bit_pending <= 1'b0;
      byte_count        <= '0;
      bit_count         <= 4'd0;
      shift_byte        <= 8'd0;
      dest_nibble       <= 4'd0;
      eom_seen          <= 1'b0;
      acked_flag        <= 1'b0;
      abort_flag        <= 1'b0;
      ready_flag        <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      last_mark_time    <= last_mark_time_next;
      first_bit_pending <= first_bit_pending_next;
      byte_count        <= byte_count_next;
      bit_count         <= bit_count_next;
      shift_byte        <= shift_byte_next;
      dest_nibble       <= dest_nibble_next;
      eom_seen          <= eom_seen_next;
      acked_flag        <= acked_flag_next;
      abort_flag        <= abort_flag_next;
      ready_flag        <= ready_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
    if (step) begin
      m_tdata <= {2'b00,
                  abort_flag_next,
                  acked_flag_next,
                  ready_flag_next ? count_next_ext[4:0] : 5'd0,
                  ready_flag_next,
                  byte_index_c,
                  byte_value_c,
                  byte_valid_c,
                  ack_pull_c};
    end
  end

endmodule

/* bench/cec_rx_checker.sv */
`timescale 1ns / 1ps
// Checker for the CEC bit receiver: watches the edge, status and address channels,
// predicts every status word and compares it field by field. Depends on cec_rx_pkg.
module cec_rx_checker
  import cec_rx_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int          mismatch_count,
  output int          open_results
);

  typedef struct packed {
    logic       ack_pull;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    logic       frame_done;
    logic [4:0] frame_length;
    logic       acked_frame;
    logic       aborted;
  } rx_status_t;

  phase_t      ph;
  logic [31:0] mark_us;
  logic        first_bit;
  logic [5:0]  bytes_done;
  logic [3:0]  bits_done;
  logic [7:0]  shreg;
  logic [3:0]  dest;
  logic        eom;
  logic        acked;
  logic        aborted_f;
  logic        done_f;
  logic [3:0]  my_addr;
  rx_status_t  status_due[$];
  int          edges_in = 0;
  int          status_out = 0;
  int          errors = 0;

  assign open_results   = edges_in - status_out;
  assign mismatch_count = errors;

  function automatic void clear_frame();
    ph         = PH_START_LOW;
    mark_us    = '0;
    first_bit  = 1'b0;
    bytes_done = '0;
    bits_done  = '0;
    shreg      = '0;
    dest       = '0;
    eom        = 1'b0;
    acked      = 1'b0;
    aborted_f  = 1'b0;
    done_f     = 1'b0;
  endfunction

  function automatic void abort_frame();
    ph        = PH_ABORT;
    aborted_f = 1'b1;
  endfunction

  function automatic rx_status_t decode_edge(input logic act, input logic rising,
                                             input logic [31:0] now);
    rx_status_t  r;
    logic [31:0] dt;
    logic        is_one;
    logic        is_zero;
    logic        start_ok;
    logic        per_ok;
    r        = '0;
    dt       = now - mark_us;
    is_one   = (dt >= ONE_LOW_MIN) && (dt <= ONE_LOW_MAX);
    is_zero  = (dt >= ZERO_LOW_MIN) && (dt <= ZERO_LOW_MAX);
    start_ok = (dt >= START_LOW_MIN) && (dt <= START_LOW_MAX);
    per_ok   = first_bit ? ((dt >= START_PER_MIN) && (dt <= START_PER_MAX)) :
                           ((dt >= BIT_PER_MIN) && (dt <= BIT_PER_MAX));
    if (act == ACT_REARM) begin
      clear_frame();
    end else begin
      case (ph)
        PH_START_LOW: begin
          if (!rising) begin
            mark_us = now;
            ph      = PH_START_HIGH;
          end
        end
        PH_START_HIGH: begin
          if (rising && start_ok) begin
            first_bit  = 1'b1;
            bytes_done = '0;
            bits_done  = '0;
            shreg      = '0;
            ph         = PH_DATA_LOW;
          end else if (rising) begin
            abort_frame();
          end
        end
        PH_DATA_LOW, PH_EOM_LOW: begin
          if (!rising) begin
            if (ph == PH_DATA_LOW && bits_done == 0 && bytes_done >= FRAME_BYTES) begin
              abort_frame();
            end else if (per_ok) begin
              mark_us   = now;
              first_bit = 1'b0;
              ph        = (ph == PH_EOM_LOW) ? PH_EOM_HIGH : PH_DATA_HIGH;
            end else begin
              abort_frame();
            end
          end
        end
        PH_DATA_HIGH, PH_EOM_HIGH: begin
          if (rising) begin
            if (!is_one && !is_zero) begin
              abort_frame();
            end else if (ph == PH_EOM_HIGH) begin
              eom = is_one;
              ph  = PH_ACK_LOW;
            end else begin
              shreg     = {shreg[6:0], is_one};
              bits_done = bits_done + 1'b1;
              if (bits_done == 4'd8) begin
                r.byte_valid = 1'b1;
                r.byte_value = shreg;
                r.byte_index = bytes_done[3:0];
                if (bytes_done == 0) dest = shreg[3:0];
                bytes_done = bytes_done + 1'b1;
                bits_done  = '0;
                shreg      = '0;
                ph         = PH_EOM_LOW;
              end else begin
                ph = PH_DATA_LOW;
              end
            end
          end
        end
        PH_ACK_LOW: begin
          if (!rising) begin
            mark_us = now;
            if (dest != BROADCAST_ADDR && dest == my_addr) begin
              r.ack_pull = 1'b1;
              acked      = 1'b1;
            end
            ph = PH_ACK_HIGH;
          end
        end
        PH_ACK_HIGH: begin
          if (rising) begin
            if (!is_one && !is_zero) begin
              abort_frame();
            end else if (eom) begin
              ph     = PH_DONE;
              done_f = 1'b1;
            end else begin
              ph = PH_DATA_LOW;
            end
          end
        end
        default: ;
      endcase
    end
    r.frame_done   = done_f;
    r.frame_length = done_f ? bytes_done[4:0] : 5'd0;
    r.acked_frame  = acked;
    r.aborted      = aborted_f;
    return r;
  endfunction

  function automatic int field_bad(input string fname, input int unsigned want,
                                   input int unsigned got);
    if (want == got) return 0;
    $display("%0t ns: %s expected %0d, actual %0d", $time, fname, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    rx_status_t want;
    rx_status_t got;
    if (rst) begin
      my_addr = OWN_ADDR_RST;
      clear_frame();
      status_due.delete();
      edges_in   <= 0;
      status_out <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        status_out <= status_out + 1;
        got.ack_pull     = m_tdata[0];
        got.byte_valid   = m_tdata[1];
        got.byte_value   = m_tdata[9:2];
        got.byte_index   = m_tdata[13:10];
        got.frame_done   = m_tdata[14];
        got.frame_length = m_tdata[19:15];
        got.acked_frame  = m_tdata[20];
        got.aborted      = m_tdata[21];
        if (status_due.size() == 0) begin
          $display("%0t ns: status expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = status_due.pop_front();
          errors += field_bad("ack_pull", 32'(want.ack_pull), 32'(got.ack_pull))
                  + field_bad("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid))
                  + field_bad("byte_value", 32'(want.byte_value), 32'(got.byte_value))
                  + field_bad("byte_index", 32'(want.byte_index), 32'(got.byte_index))
                  + field_bad("frame_done", 32'(want.frame_done), 32'(got.frame_done))
                  + field_bad("frame_length", 32'(want.frame_length),
                              32'(got.frame_length))
                  + field_bad("acked_frame", 32'(want.acked_frame),
                              32'(got.acked_frame))
                  + field_bad("aborted", 32'(want.aborted), 32'(got.aborted));
        end
      end
      if (cfg_valid && cfg_ready) my_addr = cfg_data;
      if (s_tvalid && s_tready) begin
        status_due.push_back(decode_edge(s_tuser[0], s_tdata[0], s_tdata[32:1]));
        edges_in <= edges_in + 1;
      end
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench top for cec_bit_receiver_top: drives edge, rearm and address
// transactions and gives the verdict. Depends on cec_rx_pkg and cec_rx_checker.
module tb;
  import cec_rx_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;
  int          mismatch_count;
  int          open_results;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          glitch_rate = 0;
  bit          spurious_on = 1'b0;
  logic [31:0] line_us = '0;
  logic [3:0]  own_addr_now = OWN_ADDR_RST;
  int          items_sent = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  cec_bit_receiver_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  cec_rx_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .open_results   (open_results)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic act, input logic rising, input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'd0, t, rising};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  task automatic write_address(input logic [3:0] addr);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    own_addr_now = addr;
  endtask

  // Pick a duration inside the window, at its bounds now and then; when the frame
  // carries timing faults, sometimes just outside it or anywhere up to 6000 instead.
  function automatic logic [31:0] timing(input int unsigned lo, input int unsigned hi);
    int unsigned pick;
    pick = $urandom_range(99);
    if (glitch_rate != 0 && $urandom_range(glitch_rate - 1) == 0)
      return (pick < 40) ? lo - 1 : ((pick < 80) ? hi + 1 : $urandom_range(6000));
    if (pick < 10) return lo;
    if (pick < 20) return hi;
    return $urandom_range(hi, lo);
  endfunction

  task automatic send_edge(input logic rising, input logic [31:0] t);
    if (spurious_on && $urandom_range(49) == 0) send_item(ACT_EDGE, !rising, $urandom);
    send_item(ACT_EDGE, rising, t);
  endtask

  task automatic send_bit(input logic value);
    send_edge(1'b0, line_us);
    send_edge(1'b1, line_us + (value ? timing(ONE_LOW_MIN, ONE_LOW_MAX) :
                                       timing(ZERO_LOW_MIN, ZERO_LOW_MAX)));
    line_us += timing(BIT_PER_MIN, BIT_PER_MAX);
  endtask

  task automatic send_frame(input int nbytes, input logic [7:0] hdr, input logic eom_last);
    logic [7:0] cur;
    send_item(ACT_REARM, 1'($urandom_range(1)), $urandom);
    line_us = $urandom;
    send_edge(1'b0, line_us);
    send_edge(1'b1, line_us + timing(START_LOW_MIN, START_LOW_MAX));
    line_us += timing(START_PER_MIN, START_PER_MAX);
    for (int i = 0; i < nbytes; i++) begin
      cur = (i == 0) ? hdr : 8'($urandom_range(255));
      for (int k = 7; k >= 0; k--) send_bit(cur[k]);
      send_bit((i == nbytes - 1) ? eom_last : 1'b0);
      send_bit(1'($urandom_range(1)));
    end
  endtask

  task automatic random_frame();
    int         pick;
    int         nbytes;
    logic [7:0] hdr;
    pick = $urandom_range(99);
    if (pick < 70) nbytes = $urandom_range(3, 1);
    else if (pick < 95) nbytes = $urandom_range(8, 4);
    else nbytes = $urandom_range(FRAME_BYTES_DEF, 9);
    pick = $urandom_range(99);
    hdr[7:4] = 4'($urandom_range(15));
    if (pick < 60) hdr[3:0] = own_addr_now;
    else if (pick < 75) hdr[3:0] = BROADCAST_ADDR;
    else hdr[3:0] = 4'($urandom_range(15));
    glitch_rate = ($urandom_range(99) < 30) ? 40 : 0;
    spurious_on = ($urandom_range(99) < 20);
    send_frame(nbytes, hdr, $urandom_range(99) < 90);
  endtask

  initial begin
    logic [31:0] t;
    logic [3:0]  addr;
    int          target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_address(4'h3);

    send_item(ACT_REARM, 1'b1, 32'hffff_ffff);
    send_item(ACT_EDGE, 1'b1, 32'h0000_0000);
    t = 32'hffff_f000;
    send_item(ACT_EDGE, 1'b0, t);
    send_item(ACT_EDGE, 1'b0, 32'h1234_5678);
    send_item(ACT_EDGE, 1'b1, t + START_LOW_MAX);
    t += START_PER_MIN;
    send_item(ACT_EDGE, 1'b0, t);
    send_item(ACT_EDGE, 1'b1, t + ONE_LOW_MIN);
    t += BIT_PER_MAX;
    send_item(ACT_EDGE, 1'b0, t);
    send_item(ACT_EDGE, 1'b1, t + ZERO_LOW_MAX);
    t += BIT_PER_MIN;
    send_item(ACT_EDGE, 1'b0, t);
    send_item(ACT_EDGE, 1'b1, t + ONE_LOW_MAX + 1);
    send_item(ACT_EDGE, 1'b0, t + BIT_PER_MAX);
    send_item(ACT_REARM, 1'b0, 32'h0000_0000);
    t = 32'h8000_0000;
    send_item(ACT_EDGE, 1'b0, t);
    send_item(ACT_EDGE, 1'b1, t + START_LOW_MIN - 1);
    send_item(ACT_REARM, 1'b0, 32'h0000_0000);
    send_item(ACT_EDGE, 1'b0, 32'h0000_0000);
    send_item(ACT_EDGE, 1'b1, START_LOW_MIN);
    send_item(ACT_EDGE, 1'b0, START_PER_MAX + 1);
    send_item(ACT_EDGE, 1'b0, START_PER_MAX + ZERO_LOW_MIN);

    for (int p = 0; p < 4; p++) begin
      wait_results();
      case (p)
        0: begin
          addr          = 4'h0;
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          addr          = 4'hf;
          send_idle_pct = 54;
          stall_pct     = 0;
        end
        2: begin
          addr          = 4'($urandom_range(15));
          send_idle_pct = 0;
          stall_pct     = 54;
        end
        default: begin
          addr          = 4'($urandom_range(15));
          send_idle_pct = 36;
          stall_pct     = 36;
        end
      endcase
      write_address(addr);
      glitch_rate = 0;
      spurious_on = 1'b0;
      if (p == 2) send_frame(FRAME_BYTES_DEF + 1, {4'h4, own_addr_now}, 1'b1);
      target = items_sent + 40;
      while (items_sent < target) begin
        random_frame();
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(3, 1))
            send_item($urandom_range(3) == 0, 1'($urandom_range(1)), $urandom);
        if ($urandom_range(15) == 0) wait_results();
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/cec_rx_pkg.sv
src/cec_bit_receiver_top.sv
bench/cec_rx_checker.sv
bench/tb.sv
